// ----- rtl/fdt_structure_token_walker_macros.svh -----
// assertion macros used by the walker's checker file
// no dependencies; callers supply clock, reset and property expressions
`ifndef FDT_STRUCTURE_TOKEN_WALKER_MACROS_SVH
`define FDT_STRUCTURE_TOKEN_WALKER_MACROS_SVH

// implication checked in the same cycle, disabled while reset is asserted
`define FDTW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fdtw same-cycle check failed");

// implication checked in the next cycle, disabled while reset is asserted
`define FDTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fdtw next-cycle check failed");

`endif

// ----- rtl/fdtw_pkg.sv -----
// shared types and constants for the device tree structure walker
// no dependencies; used by the interfaces, all rtl modules and the checker
package fdtw_pkg;

	// result kinds
	localparam logic [2:0] KIND_PROP        = 3'd0;
	localparam logic [2:0] KIND_END         = 3'd1;
	localparam logic [2:0] KIND_BAD_MAGIC   = 3'd2;
	localparam logic [2:0] KIND_BAD_VERSION = 3'd3;
	localparam logic [2:0] KIND_BAD_TOKEN   = 3'd4;
	localparam logic [2:0] KIND_TOO_LONG    = 3'd5;

	// structure block tokens
	localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
	localparam logic [31:0] TOK_END_NODE   = 32'd2;
	localparam logic [31:0] TOK_PROP       = 32'd3;
	localparam logic [31:0] TOK_NOP        = 32'd4;
	localparam logic [31:0] TOK_END        = 32'd9;

	// header word positions
	localparam logic [31:0] HDR_TOTAL_SIZE  = 32'd1;
	localparam logic [31:0] HDR_OFF_STRUCT  = 32'd2;
	localparam logic [31:0] HDR_OFF_STRINGS = 32'd3;
	localparam logic [31:0] HDR_VERSION     = 32'd5;

	// configuration register indexes and reset values
	localparam logic CFG_MAGIC   = 1'b0;
	localparam logic CFG_VERSION = 1'b1;
	localparam logic [31:0] MAGIC_RESET   = 32'hD00D_FEED;
	localparam logic [31:0] VERSION_RESET = 32'd17;

	// ceil(length / 4) of a 32-bit length needs 31 bits
	localparam int SKIP_W = 31;

	typedef struct packed {
		logic [31:0] blob_word;
		logic        first_word;
	} fdtw_word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] token_offset;
		logic [15:0] data_offset;
		logic [31:0] data_length;
		logic [31:0] name_offset;
		logic [17:0] node_name_offset;
		logic [31:0] total_size;
	} fdtw_result_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] version;
	} fdtw_cfg_t;

	// one word handed from the input stage to the walker
	typedef struct packed {
		logic        go;
		logic        first;
		logic [31:0] word;
	} fdtw_step_t;

endpackage

// ----- rtl/fdtw_stream_if.sv -----
// valid/ready stream interfaces for blob words and walker results
// depends on fdtw_pkg for the payload types
interface fdtw_word_if;
	logic              valid;
	logic              ready;
	fdtw_pkg::fdtw_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface fdtw_result_if;
	logic                valid;
	logic                ready;
	fdtw_pkg::fdtw_result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/fdt_structure_token_walker.sv -----
// top level of the flattened device tree structure walker
// depends on fdtw_pkg, fdtw_stream_if, fdtw_walker and fdtw_out_buf
//
// usage
//  - word_ch carries one big-endian blob word per beat; first_word set marks
//    word 0 and restarts parsing from any phase
//  - result_ch carries at most one result beat per word: a property, the end
//    token, or an error (bad magic, bad version, bad token, blob too long)
//  - cfg_we/cfg_index/cfg_wdata write the expected magic (index 0) and the
//    expected version (index 1); write only while the block is idle
//  - an accepted word waits in the input register, and the walker's result
//    then goes into the output register that drives result_ch, or into the skid entry
//  - throughput: one word per cycle while the skid entry is free, set by the
//    input register feeding the phase machine in fdtw_walker
//  - when result_ch stalls, the output register and a single skid entry
//    absorb results; word_ch ready drops when skid and input register are full
//  - reset (arst_n low) returns the walker to idle, clears all latched
//    header values and restores the reset magic and version
//  - after an error or the end token, words are ignored until a first word
module fdt_structure_token_walker #(
	parameter int MAX_BLOB_WORDS = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	fdtw_word_if.sink    word_ch,
	fdtw_result_if.source result_ch,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata
);

	// configuration registers
	fdtw_pkg::fdtw_cfg_t cfg_q;

	// input register
	logic        valid_s1;
	logic        first_s1;
	logic [31:0] word_s1;

	// walker and output buffer handshake
	fdtw_pkg::fdtw_step_t   step;
	fdtw_pkg::fdtw_result_t res;
	logic                   res_valid;
	logic                   buf_space;
	logic                   in_beat;

	// input stage advances whenever the skid entry is free or the input register is empty
	assign word_ch.ready = !valid_s1 || buf_space;
	assign in_beat       = word_ch.valid && word_ch.ready;

	assign step.go    = valid_s1 && buf_space;
	assign step.first = first_s1;
	assign step.word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic   <= fdtw_pkg::MAGIC_RESET;
			cfg_q.version <= fdtw_pkg::VERSION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fdtw_pkg::CFG_MAGIC: begin
					cfg_q.magic <= cfg_wdata;
				end
				fdtw_pkg::CFG_VERSION: begin
					cfg_q.version <= cfg_wdata;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (step.go) begin
			valid_s1 <= 1'b0;
		end
	end

	// word payload, no reset
	always_ff @(posedge clk) begin
		if (in_beat) begin
			word_s1  <= word_ch.payload.blob_word;
			first_s1 <= word_ch.payload.first_word;
		end
	end

	fdtw_walker #(
		.MAX_BLOB_WORDS(MAX_BLOB_WORDS)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.step     (step),
		.res_valid(res_valid),
		.res      (res)
	);

	fdtw_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.space    (buf_space),
		.res_ch   (result_ch)
	);

endmodule

// ----- rtl/fdtw_walker.sv -----
// header check and structure token phase machine, one word per step
// depends on fdtw_pkg
module fdtw_walker #(
	parameter int MAX_BLOB_WORDS = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fdtw_pkg::fdtw_cfg_t    cfg,
	input  fdtw_pkg::fdtw_step_t   step,
	output logic                   res_valid,
	output fdtw_pkg::fdtw_result_t res
);

	localparam int IDX_W = $clog2(MAX_BLOB_WORDS + 1);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_HEADER  = 3'd1;
	localparam logic [2:0] PH_SKIP    = 3'd2;
	localparam logic [2:0] PH_TOKEN   = 3'd3;
	localparam logic [2:0] PH_NAME    = 3'd4;
	localparam logic [2:0] PH_LEN     = 3'd5;
	localparam logic [2:0] PH_NAMEOFF = 3'd6;
	localparam logic [2:0] PH_DATA    = 3'd7;

	logic [2:0]                  phase_q, phase_d;
	logic [IDX_W-1:0]            idx_q, idx_d;
	logic [31:0]                 struct_off_q, struct_off_d;
	logic [31:0]                 strings_off_q, strings_off_d;
	logic [31:0]                 size_q, size_d;
	logic [fdtw_pkg::SKIP_W-1:0] skip_q, skip_d, skip_dec;
	logic [31:0]                 len_q, len_d;
	logic [15:0]                 tok_q, tok_d;
	logic [17:0]                 node_q, node_d;

	logic [31:0] w;
	logic [31:0] idx32;
	logic [31:0] idx_next32;
	logic        too_long;
	logic        zero_byte;
	logic        token_here;

	assign w          = step.word;
	assign idx32      = 32'(idx_q);
	assign idx_next32 = idx32 + 32'd1;
	assign too_long   = idx_q >= IDX_W'(MAX_BLOB_WORDS);
	assign zero_byte  = (w[31:24] == 8'd0) || (w[23:16] == 8'd0) ||
		(w[15:8] == 8'd0) || (w[7:0] == 8'd0);
	assign skip_dec   = skip_q - fdtw_pkg::SKIP_W'(skip_q != '0);

	always_comb begin
		phase_d       = phase_q;
		idx_d         = idx_q;
		struct_off_d  = struct_off_q;
		strings_off_d = strings_off_q;
		size_d        = size_q;
		skip_d        = skip_q;
		len_d         = len_q;
		tok_d         = tok_q;
		node_d        = node_q;
		token_here    = 1'b0;
		res_valid     = 1'b0;
		res.kind             = fdtw_pkg::KIND_PROP;
		res.token_offset     = 16'd0;
		res.data_offset      = 16'd0;
		res.data_length      = 32'd0;
		res.name_offset      = 32'd0;
		res.node_name_offset = step.first ? 18'd0 : node_q;
		res.total_size       = step.first ? 32'd0 : size_q;

		if (step.go) begin
			if (step.first) begin
				struct_off_d  = 32'd0;
				strings_off_d = 32'd0;
				size_d        = 32'd0;
				skip_d        = '0;
				len_d         = 32'd0;
				tok_d         = 16'd0;
				node_d        = 18'd0;
				idx_d         = IDX_W'(1);
				if (w != cfg.magic) begin
					phase_d   = PH_IDLE;
					res_valid = 1'b1;
					res.kind  = fdtw_pkg::KIND_BAD_MAGIC;
				end else begin
					phase_d = PH_HEADER;
				end
			end else if (phase_q != PH_IDLE) begin
				if (too_long) begin
					phase_d          = PH_IDLE;
					res_valid        = 1'b1;
					res.kind         = fdtw_pkg::KIND_TOO_LONG;
					res.token_offset = idx32[15:0];
				end else begin
					idx_d = idx_q + IDX_W'(1);
					case (phase_q)
						PH_HEADER: begin
							if (idx32 == fdtw_pkg::HDR_TOTAL_SIZE) begin
								size_d = w;
							end else if (idx32 == fdtw_pkg::HDR_OFF_STRUCT) begin
								struct_off_d = w;
							end else if (idx32 == fdtw_pkg::HDR_OFF_STRINGS) begin
								strings_off_d = w;
							end else if (idx32 >= fdtw_pkg::HDR_VERSION) begin
								if (w != cfg.version) begin
									phase_d          = PH_IDLE;
									res_valid        = 1'b1;
									res.kind         = fdtw_pkg::KIND_BAD_VERSION;
									res.token_offset = idx32[15:0];
								end else begin
									phase_d = PH_SKIP;
								end
							end
						end
						PH_SKIP: begin
							// two low offset bits are dropped
							if (idx32 >= {2'b00, struct_off_q[31:2]}) begin
								token_here = 1'b1;
							end
						end
						PH_TOKEN: begin
							token_here = 1'b1;
						end
						PH_NAME: begin
							if (zero_byte) begin
								phase_d = PH_TOKEN;
							end
						end
						PH_LEN: begin
							len_d   = w;
							phase_d = PH_NAMEOFF;
						end
						PH_NAMEOFF: begin
							skip_d = {1'b0, len_q[31:2]} +
								fdtw_pkg::SKIP_W'(len_q[1:0] != 2'b00);
							phase_d = (len_q != 32'd0) ? PH_DATA : PH_TOKEN;
							res_valid        = 1'b1;
							res.kind         = fdtw_pkg::KIND_PROP;
							res.token_offset = tok_q;
							res.data_offset  = idx_next32[15:0];
							res.data_length  = len_q;
							res.name_offset  = strings_off_q + w;
						end
						PH_DATA: begin
							skip_d = skip_dec;
							if (skip_dec == '0) begin
								phase_d = PH_TOKEN;
							end
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase

					if (token_here) begin
						phase_d = PH_TOKEN;
						case (w)
							fdtw_pkg::TOK_BEGIN_NODE: begin
								node_d  = {idx_next32[15:0], 2'b00};
								phase_d = PH_NAME;
							end
							fdtw_pkg::TOK_END_NODE, fdtw_pkg::TOK_NOP: begin
								phase_d = PH_TOKEN;
							end
							fdtw_pkg::TOK_PROP: begin
								tok_d   = idx32[15:0];
								phase_d = PH_LEN;
							end
							fdtw_pkg::TOK_END: begin
								phase_d          = PH_IDLE;
								res_valid        = 1'b1;
								res.kind         = fdtw_pkg::KIND_END;
								res.token_offset = idx32[15:0];
							end
							default: begin
								phase_d          = PH_IDLE;
								res_valid        = 1'b1;
								res.kind         = fdtw_pkg::KIND_BAD_TOKEN;
								res.token_offset = idx32[15:0];
							end
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			idx_q         <= '0;
			struct_off_q  <= 32'd0;
			strings_off_q <= 32'd0;
			size_q        <= 32'd0;
			skip_q        <= '0;
			len_q         <= 32'd0;
			tok_q         <= 16'd0;
			node_q        <= 18'd0;
		end else begin
			phase_q       <= phase_d;
			idx_q         <= idx_d;
			struct_off_q  <= struct_off_d;
			strings_off_q <= strings_off_d;
			size_q        <= size_d;
			skip_q        <= skip_d;
			len_q         <= len_d;
			tok_q         <= tok_d;
			node_q        <= node_d;
		end
	end

endmodule

// ----- rtl/fdtw_out_buf.sv -----
// result register with one skid entry, so upstream ready is a register
// depends on fdtw_pkg and fdtw_result_if
module fdtw_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  fdtw_pkg::fdtw_result_t push_data,
	output logic                   space,
	fdtw_result_if.source          res_ch
);

	logic                   out_valid_q;
	fdtw_pkg::fdtw_result_t out_data_q;
	logic                   skid_valid_q;
	fdtw_pkg::fdtw_result_t skid_data_q;
	logic                   pop;

	assign pop            = out_valid_q && res_ch.ready;
	assign space          = !skid_valid_q;
	assign res_ch.valid   = out_valid_q;
	assign res_ch.payload = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload path, no reset
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

endmodule

// ----- rtl/fdtw_checker.sv -----
// port-level checks on the walker's result channel, bound to the top level
// depends on fdtw_pkg and fdt_structure_token_walker_macros.svh
`include "fdt_structure_token_walker_macros.svh"

module fdtw_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input fdtw_pkg::fdtw_result_t out_res
);

	// only the six defined kinds ever leave the block
	`FDTW_ASSERT_SAME(a_kind_range, clk, arst_n, out_valid,
		out_res.kind <= fdtw_pkg::KIND_TOO_LONG)

	// only a property result carries data and name fields
	`FDTW_ASSERT_SAME(a_nonprop_zero, clk, arst_n,
		out_valid && (out_res.kind != fdtw_pkg::KIND_PROP),
		(out_res.data_offset == 16'd0) && (out_res.data_length == 32'd0) &&
		(out_res.name_offset == 32'd0))

	// a bad magic word restarts the blob, so nothing latched shows
	`FDTW_ASSERT_SAME(a_magic_clean, clk, arst_n,
		out_valid && (out_res.kind == fdtw_pkg::KIND_BAD_MAGIC),
		(out_res.token_offset == 16'd0) && (out_res.total_size == 32'd0) &&
		(out_res.node_name_offset == 18'd0))

	// a stalled result beat holds
	`FDTW_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_res))

endmodule

bind fdt_structure_token_walker fdtw_checker u_fdtw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(result_ch.valid),
	.out_ready(result_ch.ready),
	.out_res  (result_ch.payload)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for the device tree structure walker, driven beat by beat
// depends on fdtw_pkg, fdtw_stream_if and fdt_structure_token_walker

module tb_top;

	localparam int MAX_WORDS      = 65536;
	localparam int DRAIN_CYCLES   = 8;     // quiet margin after the last predicted result beat
	localparam int WATCHDOG_LIMIT = 5000;  // longest quiet stretch is the result hold of test_result_backpressure
	localparam int RANDOM_WORDS   = 340;   // per idling profile, three profiles in all

	// phases of the walker as the predictor tracks them
	typedef enum logic [2:0] {
		WALK_IDLE, WALK_HEADER, WALK_SKIP, WALK_TOKEN,
		WALK_NAME, WALK_LEN, WALK_NAMEOFF, WALK_DATA
	} walk_phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;

	fdtw_word_if   word_ch();
	fdtw_result_if result_ch();

	fdt_structure_token_walker #(
		.MAX_BLOB_WORDS(MAX_WORDS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_ch   (word_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of the registers and walker state
	logic [31:0] want_magic;
	logic [31:0] want_version;
	walk_phase_t walk_phase;
	logic [31:0] word_idx;
	logic [31:0] struct_off;
	logic [31:0] strings_off;
	logic [31:0] total_size_lat;
	logic [31:0] skip_left;
	logic [31:0] prop_length;
	logic [15:0] prop_token;
	logic [17:0] node_off_lat;

	fdtw_pkg::fdtw_result_t pending_results[$];  // predicted result beats, oldest first
	logic [31:0]            blob_words[$];       // blob under construction

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_results = 1'b0;
	int   words_parsed = 0;   // beats the walker actually looks at
	int   errors = 0;
	int   shown = 0;
	int   stall_cycles = 0;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic fdtw_pkg::fdtw_result_t make_result(input logic [2:0] kind,
			input logic [31:0] tok, input logic [31:0] doff, input logic [31:0] dlen,
			input logic [31:0] noff);
		fdtw_pkg::fdtw_result_t r;
		r.kind             = kind;
		r.token_offset     = tok[15:0];
		r.data_offset      = doff[15:0];
		r.data_length      = dlen;
		r.name_offset      = noff;
		r.node_name_offset = node_off_lat;
		r.total_size       = total_size_lat;
		return r;
	endfunction

	function automatic bit holds_zero_byte(input logic [31:0] w);
		return w[31:24] == 8'h00 || w[23:16] == 8'h00 ||
			w[15:8] == 8'h00 || w[7:0] == 8'h00;
	endfunction

	// advance the predicted walker by one accepted word beat
	task automatic walk_word(input logic [31:0] w, input logic first);
		logic [31:0] idx;
		logic [31:0] name_byte;
		if (first) begin
			struct_off     = '0;
			strings_off    = '0;
			total_size_lat = '0;
			skip_left      = '0;
			prop_length    = '0;
			prop_token     = '0;
			node_off_lat   = '0;
			word_idx       = 32'd1;
			if (w != want_magic) begin
				walk_phase = WALK_IDLE;
				pending_results.push_back(make_result(fdtw_pkg::KIND_BAD_MAGIC,
					'0, '0, '0, '0));
			end else begin
				walk_phase = WALK_HEADER;
			end
			return;
		end
		if (walk_phase == WALK_IDLE)
			return;

		idx = word_idx;
		// index bound is checked before anything else is done with the word
		if (idx >= 32'(MAX_WORDS)) begin
			walk_phase = WALK_IDLE;
			pending_results.push_back(make_result(fdtw_pkg::KIND_TOO_LONG,
				idx, '0, '0, '0));
			return;
		end
		word_idx = idx + 32'd1;

		if (walk_phase == WALK_HEADER) begin
			if (idx == fdtw_pkg::HDR_TOTAL_SIZE) begin
				total_size_lat = w;
			end else if (idx == fdtw_pkg::HDR_OFF_STRUCT) begin
				struct_off = w;
			end else if (idx == fdtw_pkg::HDR_OFF_STRINGS) begin
				strings_off = w;
			end else if (idx >= fdtw_pkg::HDR_VERSION) begin
				if (w != want_version) begin
					walk_phase = WALK_IDLE;
					pending_results.push_back(make_result(fdtw_pkg::KIND_BAD_VERSION,
						idx, '0, '0, '0));
				end else begin
					walk_phase = WALK_SKIP;
				end
			end
			return;
		end

		// low two bits of the structure offset play no part
		if (walk_phase == WALK_SKIP) begin
			if (idx < (struct_off >> 2))
				return;
			walk_phase = WALK_TOKEN;
		end

		case (walk_phase)
			WALK_TOKEN: begin
				if (w == fdtw_pkg::TOK_BEGIN_NODE) begin
					name_byte    = (idx + 32'd1) << 2;
					node_off_lat = name_byte[17:0];
					walk_phase   = WALK_NAME;
				end else if (w == fdtw_pkg::TOK_END_NODE || w == fdtw_pkg::TOK_NOP) begin
					// single-word tokens
				end else if (w == fdtw_pkg::TOK_PROP) begin
					prop_token = idx[15:0];
					walk_phase = WALK_LEN;
				end else if (w == fdtw_pkg::TOK_END) begin
					walk_phase = WALK_IDLE;
					pending_results.push_back(make_result(fdtw_pkg::KIND_END,
						idx, '0, '0, '0));
				end else begin
					walk_phase = WALK_IDLE;
					pending_results.push_back(make_result(fdtw_pkg::KIND_BAD_TOKEN,
						idx, '0, '0, '0));
				end
			end
			WALK_NAME: begin
				if (holds_zero_byte(w))
					walk_phase = WALK_TOKEN;
			end
			WALK_LEN: begin
				prop_length = w;
				walk_phase  = WALK_NAMEOFF;
			end
			WALK_NAMEOFF: begin
				skip_left  = (prop_length >> 2) + {31'd0, prop_length[1:0] != 2'b00};
				walk_phase = (skip_left != 0) ? WALK_DATA : WALK_TOKEN;
				pending_results.push_back(make_result(fdtw_pkg::KIND_PROP,
					{16'd0, prop_token}, idx + 32'd1, prop_length, strings_off + w));
			end
			WALK_DATA: begin
				if (skip_left != 0)
					skip_left = skip_left - 32'd1;
				if (skip_left == 0)
					walk_phase = WALK_TOKEN;
			end
			default: walk_phase = WALK_IDLE;
		endcase
	endtask

	// ------------------------------------------------------------------
	// result side: random ready, long hold on request, checks each beat
	// ------------------------------------------------------------------

	task automatic check_result_beat(input fdtw_pkg::fdtw_result_t got);
		fdtw_pkg::fdtw_result_t want;
		if (pending_results.size() == 0) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("unexpected result beat: kind %0d token %0d",
					got.kind, got.token_offset);
			end
			return;
		end
		want = pending_results.pop_front();
		if (got.kind !== want.kind || got.token_offset !== want.token_offset ||
				got.data_offset !== want.data_offset ||
				got.data_length !== want.data_length ||
				got.name_offset !== want.name_offset ||
				got.node_name_offset !== want.node_name_offset ||
				got.total_size !== want.total_size) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display({"result mismatch: expected kind %0d tok %0d doff %0d",
					" len %h noff %h node %h size %h"},
					want.kind, want.token_offset, want.data_offset, want.data_length,
					want.name_offset, want.node_name_offset, want.total_size);
				$display({"                 actual   kind %0d tok %0d doff %0d",
					" len %h noff %h node %h size %h"},
					got.kind, got.token_offset, got.data_offset, got.data_length,
					got.name_offset, got.node_name_offset, got.total_size);
			end
		end
	endtask

	// sink process: sample at the edge, then pick next ready
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (result_ch.valid && result_ch.ready)
					check_result_beat(result_ch.payload);
				result_ch.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// holds the result channel off while the sender keeps going
	task automatic hold_result_channel(input int cycles);
		hold_results <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_results <= 1'b0;
	endtask

	// watchdog: too long with no beat on either channel ends the run
	always @(posedge clk) begin
		if ((word_ch.valid && word_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// word side
	// ------------------------------------------------------------------

	// offers one word beat, with random gaps ahead of it, and predicts on acceptance
	task automatic send_word(input logic [31:0] w, input logic first);
		while ($urandom_range(99) < send_idle_pct) begin
			word_ch.valid <= 1'b0;
			@(posedge clk);
		end
		word_ch.valid   <= 1'b1;
		word_ch.payload <= {w, first};
		@(posedge clk);
		while (!word_ch.ready) @(posedge clk);
		if (first || walk_phase != WALK_IDLE)
			words_parsed++;
		walk_word(w, first);
	endtask

	task automatic send_blob();
		for (int i = 0; i < blob_words.size(); i++)
			send_word(blob_words[i], i == 0);
	endtask

	// drop valid and let every predicted beat come out, then a few quiet cycles
	task automatic drain_walker();
		word_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic index, input logic [31:0] value);
		drain_walker();
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == fdtw_pkg::CFG_MAGIC)
			want_magic = value;
		else
			want_version = value;
	endtask

	// ------------------------------------------------------------------
	// blob construction
	// ------------------------------------------------------------------

	// header words 0..5, then filler up to the structure block
	task automatic start_blob(input logic [31:0] size, input logic [31:0] soff,
			input logic [31:0] stroff);
		int pad;
		blob_words.delete();
		blob_words.push_back(want_magic);
		blob_words.push_back(size);
		blob_words.push_back(soff);
		blob_words.push_back(stroff);
		blob_words.push_back($urandom);
		blob_words.push_back(want_version);
		pad = ((soff >> 2) > 6) ? int'(soff >> 2) - 6 : 0;
		repeat (pad) blob_words.push_back($urandom);
	endtask

	// name word: no zero byte unless it ends the name
	function automatic logic [31:0] name_word(input bit terminal);
		logic [31:0] w;
		int k;
		for (k = 0; k < 4; k++)
			w[8*k +: 8] = 8'($urandom_range(1, 255));
		if (terminal) begin
			if ($urandom_range(7) == 0)
				w = '0;
			else
				w[8*$urandom_range(3) +: 8] = 8'h00;
		end
		return w;
	endfunction

	task automatic add_node(input int name_len);
		blob_words.push_back(fdtw_pkg::TOK_BEGIN_NODE);
		repeat (name_len - 1) blob_words.push_back(name_word(1'b0));
		blob_words.push_back(name_word(1'b1));
	endtask

	// property with all its data words; small lengths only
	task automatic add_prop(input logic [31:0] len, input logic [31:0] nameoff);
		blob_words.push_back(fdtw_pkg::TOK_PROP);
		blob_words.push_back(len);
		blob_words.push_back(nameoff);
		repeat ((len >> 2) + (len[1:0] != 2'b00)) blob_words.push_back($urandom);
	endtask

	task automatic send_small_blob();
		start_blob($urandom, 32'd24, $urandom);
		add_node(1);
		add_prop($urandom_range(0, 8), $urandom);
		blob_words.push_back(fdtw_pkg::TOK_END);
		send_blob();
	endtask

	task automatic send_bad_version();
		start_blob($urandom, 32'd24, $urandom);
		blob_words[fdtw_pkg::HDR_VERSION] = ~want_version;
		send_blob();
	endtask

	// well-formed token stream with random content, sometimes ended badly or cut short
	task automatic send_random_blob();
		logic [31:0] soff;
		int pick;
		int n;
		bit cut;
		pick = $urandom_range(99);
		if (pick < 70)
			soff = ($urandom_range(6, 10) << 2) | $urandom_range(3);
		else if (pick < 85)
			soff = $urandom_range(0, 23);   // structure block inside the header
		else
			soff = $urandom_range(24, 120);
		start_blob($urandom, soff, $urandom);
		n   = $urandom_range(1, 12);
		cut = 1'b0;
		for (int t = 0; t < n && !cut; t++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				add_node($urandom_range(1, 3));
			end else if (pick < 35) begin
				blob_words.push_back(fdtw_pkg::TOK_END_NODE);
			end else if (pick < 42) begin
				blob_words.push_back(fdtw_pkg::TOK_NOP);
			end else if (pick < 92) begin
				add_prop($urandom_range(0, 12), $urandom);
			end else begin
				// full-range length: the next blob cuts into its data
				blob_words.push_back(fdtw_pkg::TOK_PROP);
				blob_words.push_back($urandom);
				blob_words.push_back($urandom);
				repeat ($urandom_range(0, 2)) blob_words.push_back($urandom);
				cut = 1'b1;
			end
		end
		if (!cut) begin
			pick = $urandom_range(99);
			if (pick < 84)
				blob_words.push_back(fdtw_pkg::TOK_END);
			else if (pick < 92)
				blob_words.push_back($urandom);   // almost always an unknown token
			// otherwise left unterminated, the next first word restarts
		end
		send_blob();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every token kind, wrapping name offset, words while idle, unknown tokens
	task automatic test_directed_walk();
		start_blob(32'hFFFF_FFFF, 32'd24, 32'hFFFF_FFF0);
		blob_words.push_back(fdtw_pkg::TOK_BEGIN_NODE);
		blob_words.push_back(32'h2F00_0000);
		blob_words.push_back(fdtw_pkg::TOK_BEGIN_NODE);
		blob_words.push_back(32'h6370_7573);
		blob_words.push_back(32'h0000_0000);
		add_prop(32'd5, 32'hFFFF_FFFF);
		blob_words.push_back(fdtw_pkg::TOK_END_NODE);
		blob_words.push_back(fdtw_pkg::TOK_NOP);
		add_prop(32'd0, 32'd0);
		blob_words.push_back(fdtw_pkg::TOK_END_NODE);
		blob_words.push_back(fdtw_pkg::TOK_END);
		send_blob();
		// ignored while idle
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		start_blob(32'd0, 32'd24, 32'd0);
		blob_words.push_back(fdtw_pkg::TOK_NOP);
		blob_words.push_back(32'h0000_0000);
		send_blob();
		start_blob(32'd0, 32'd24, 32'd0);
		blob_words.push_back(32'hFFFF_FFFF);
		send_blob();
	endtask

	// header errors, odd structure offsets and restarts from each phase
	task automatic test_header_cases();
		send_word(~want_magic, 1'b1);
		send_bad_version();
		// structure offset at or before word 5: tokens begin at word 6
		start_blob($urandom, 32'd0, $urandom);
		add_prop(32'd3, $urandom);
		blob_words.push_back(fdtw_pkg::TOK_END);
		send_blob();
		start_blob($urandom, 32'd20, $urandom);
		blob_words.push_back(fdtw_pkg::TOK_NOP);
		blob_words.push_back(fdtw_pkg::TOK_END);
		send_blob();
		// misaligned offset lands on word 7
		start_blob($urandom, 32'd31, $urandom);
		add_node(2);
		blob_words.push_back(fdtw_pkg::TOK_END_NODE);
		blob_words.push_back(fdtw_pkg::TOK_END);
		send_blob();
		// restart inside the header
		start_blob($urandom, 32'd24, $urandom);
		for (int i = 0; i < 3; i++)
			send_word(blob_words[i], i == 0);
		send_small_blob();
		// restart inside a node name
		start_blob($urandom, 32'd24, $urandom);
		blob_words.push_back(fdtw_pkg::TOK_BEGIN_NODE);
		blob_words.push_back(name_word(1'b0));
		send_blob();
		// restart inside the data of a maximum-length property
		start_blob($urandom, 32'd24, $urandom);
		blob_words.push_back(fdtw_pkg::TOK_PROP);
		blob_words.push_back(32'hFFFF_FFFF);
		blob_words.push_back($urandom);
		blob_words.push_back($urandom);
		blob_words.push_back($urandom);
		send_blob();
		send_small_blob();
	endtask

	// both registers at their extremes, a random setting, then back to reset
	task automatic test_config_extremes();
		logic [31:0] m;
		logic [31:0] v;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: begin m = 32'h0000_0000; v = 32'h0000_0000; end
				1: begin m = 32'hFFFF_FFFF; v = 32'hFFFF_FFFF; end
				2: begin m = $urandom;      v = $urandom;      end
				default: begin m = fdtw_pkg::MAGIC_RESET; v = fdtw_pkg::VERSION_RESET; end
			endcase
			write_cfg(fdtw_pkg::CFG_MAGIC, m);
			write_cfg(fdtw_pkg::CFG_VERSION, v);
			send_small_blob();
			send_word(~want_magic, 1'b1);
			send_bad_version();
		end
	endtask

	task automatic test_random_blobs(input int target);
		int goal;
		int blobs;
		int pick;
		goal  = words_parsed + target;
		blobs = 0;
		while (words_parsed < goal) begin
			blobs++;
			// fresh register setting now and then, half the time the reset values
			if (blobs % 25 == 0) begin
				write_cfg(fdtw_pkg::CFG_MAGIC,
					$urandom_range(1) ? $urandom : fdtw_pkg::MAGIC_RESET);
				write_cfg(fdtw_pkg::CFG_VERSION,
					$urandom_range(1) ? $urandom : fdtw_pkg::VERSION_RESET);
			end
			pick = $urandom_range(99);
			if (pick < 5)
				repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);   // stray words
			else if (pick < 10)
				send_word($urandom, 1'b1);
			else if (pick < 14)
				send_bad_version();
			else
				send_random_blob();
		end
	endtask

	// dense property results against a held-off sink: output and skid fill, input stalls
	task automatic test_result_backpressure();
		start_blob($urandom, 32'd24, $urandom);
		add_node(1);
		repeat (40) add_prop(32'd0, $urandom);
		blob_words.push_back(fdtw_pkg::TOK_END);
		fork
			hold_result_channel(300);
			send_blob();
		join
	endtask

	// structure block near the top of the index range, then one word too many
	task automatic test_blob_too_long();
		start_blob($urandom, 32'h0003_FFE8, $urandom);   // tokens from word 65530
		blob_words.push_back(fdtw_pkg::TOK_BEGIN_NODE);
		blob_words.push_back(name_word(1'b1));
		blob_words.push_back(fdtw_pkg::TOK_NOP);
		blob_words.push_back(fdtw_pkg::TOK_PROP);
		blob_words.push_back(32'd0);
		blob_words.push_back($urandom);             // data offset wraps to zero
		blob_words.push_back(fdtw_pkg::TOK_NOP);    // word 65536: over the bound
		send_blob();
		send_word($urandom, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n          <= 1'b0;
		word_ch.valid   <= 1'b0;
		word_ch.payload <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= fdtw_pkg::CFG_MAGIC;
		cfg_wdata       <= '0;
		want_magic      = fdtw_pkg::MAGIC_RESET;
		want_version    = fdtw_pkg::VERSION_RESET;
		walk_phase      = WALK_IDLE;
		word_idx        = '0;
		struct_off      = '0;
		strings_off     = '0;
		total_size_lat  = '0;
		skip_left       = '0;
		prop_length     = '0;
		prop_token      = '0;
		node_off_lat    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sparse sender gaps, mostly stalled sink
		send_idle_pct = 15;
		recv_idle_pct = 82;
		test_directed_walk();
		test_header_cases();
		test_config_extremes();
		test_random_blobs(RANDOM_WORDS);

		// mostly idle sender, sink rarely stalls
		send_idle_pct = 82;
		recv_idle_pct = 15;
		test_random_blobs(RANDOM_WORDS);
		test_result_backpressure();

		// full rate both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_blobs(RANDOM_WORDS);
		test_result_backpressure();
		test_blob_too_long();

		drain_walker();
		if (errors == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
